[rtl/ring_buffer_allocator_unit_defines.svh]
// assertion macros used by the allocator controller rtl
`ifndef RING_BUFFER_ALLOCATOR_UNIT_DEFINES_SVH
`define RING_BUFFER_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define RBA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RBA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define RBA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/rba_pkg.sv]
package rba_pkg;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_RETRY    = 3'd1,
    STAT_BADSIZE  = 3'd2,
    STAT_FREED    = 3'd3,
    STAT_IGNORED  = 3'd4,
    STAT_INACTIVE = 3'd5
  } status_t;

  // request kinds
  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_SIZE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALIGN_SHIFT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE      = 2'd2;

  // configuration reset values
  localparam logic [31:0] POOL_SIZE_RST   = 32'd1048576;
  localparam logic [4:0]  ALIGN_SHIFT_RST = 5'd12;
  localparam logic        ENABLE_RST      = 1'b1;

  // request beat
  typedef struct packed {
    logic        action;
    logic [31:0] size;
    logic [5:0]  tag;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] offset;
    logic [5:0]  slot_tag;
    logic [31:0] used_bytes;
    logic [6:0]  retired;
  } out_item_t;

  // live configuration
  typedef struct packed {
    logic [31:0] pool_size;
    logic [4:0]  align_shift;
    logic        enable;
  } cfg_t;

  // slot memory controls
  typedef struct packed {
    logic region_we;
    logic pend_we;
    logic pend_bit;
    logic rd_en;
  } mem_ctl_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_FREE_RD,
    S_FREE_CHK
  } fsm_state_t;

endpackage

[rtl/rba_slot_mem.sv]
module rba_slot_mem #(
  parameter int SLOTS     = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                     clk,
  input  rba_pkg::mem_ctl_t        ctl,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  logic [ADDR_BITS-1:0]     wr_end,
  input  logic [ADDR_BITS-1:0]     wr_len,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output logic [ADDR_BITS-1:0]     rd_end,
  output logic [ADDR_BITS-1:0]     rd_len,
  output logic                     rd_pend
);

  // per-slot region end and length, and per-slot pending flag
  logic [2*ADDR_BITS-1:0] region_mem [SLOTS];
  logic                   pend_mem   [SLOTS];

  logic [2*ADDR_BITS-1:0] rd_region_r;
  logic                   rd_pend_r;

  // write ports
  always_ff @(posedge clk) begin
    if (ctl.region_we) begin
      region_mem[waddr] <= {wr_end, wr_len};
    end
    if (ctl.pend_we) begin
      pend_mem[waddr] <= ctl.pend_bit;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_region_r <= region_mem[raddr];
      rd_pend_r   <= pend_mem[raddr];
    end
  end

  assign rd_end  = rd_region_r[2*ADDR_BITS-1:ADDR_BITS];
  assign rd_len  = rd_region_r[ADDR_BITS-1:0];
  assign rd_pend = rd_pend_r;

endmodule

[rtl/rba_ctrl.sv]
`include "ring_buffer_allocator_unit_defines.svh"

module rba_ctrl #(
  parameter int SLOTS     = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rba_pkg::cfg_t            cfg,
  input  logic                     start,
  output logic                     busy,
  input  rba_pkg::in_item_t        in_data,
  output logic                     out_valid,
  output rba_pkg::out_item_t       out_data,
  output rba_pkg::mem_ctl_t        mem_ctl,
  output logic [$clog2(SLOTS)-1:0] waddr,
  output logic [ADDR_BITS-1:0]     wr_end,
  output logic [ADDR_BITS-1:0]     wr_len,
  output logic [$clog2(SLOTS)-1:0] raddr,
  input  logic [ADDR_BITS-1:0]     rd_end,
  input  logic [ADDR_BITS-1:0]     rd_len,
  input  logic                     rd_pend
);

  localparam int AW    = ADDR_BITS;
  localparam int TAG_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CW    = (AW > 33) ? AW : 33;
  localparam int IW    = (TAG_W > 6) ? TAG_W + 1 : 7;
  localparam logic [TAG_W-1:0] SLOT_LAST = TAG_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  // width adapters toward the fixed result fields
  function automatic logic [31:0] to_word(input logic [AW-1:0] v);
    logic [AW+31:0] ext;
    ext = {32'b0, v};
    return ext[31:0];
  endfunction

  function automatic logic [5:0] to_tag(input logic [TAG_W-1:0] v);
    logic [TAG_W+5:0] ext;
    ext = {6'b0, v};
    return ext[5:0];
  endfunction

  function automatic logic [6:0] to_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W+6:0] ext;
    ext = {7'b0, v};
    return ext[6:0];
  endfunction

  function automatic rba_pkg::out_item_t mk_beat(input rba_pkg::status_t st,
                                                 input logic [31:0] off,
                                                 input logic [5:0] tg,
                                                 input logic [31:0] used,
                                                 input logic [6:0] ret);
    rba_pkg::out_item_t b;
    b.status     = st;
    b.offset     = off;
    b.slot_tag   = tg;
    b.used_bytes = used;
    b.retired    = ret;
    return b;
  endfunction

  rba_pkg::fsm_state_t state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [AW-1:0]       bytes_r, bytes_nxt;
  logic [TAG_W-1:0]    oldest_r, oldest_nxt;
  logic [TAG_W-1:0]    next_r, next_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    retired_r, retired_nxt;
  logic [AW-1:0]       aligned_r, aligned_nxt;
  logic                bad_r, bad_nxt;
  logic                out_valid_r, out_valid_nxt;
  rba_pkg::out_item_t  out_data_r, out_data_nxt;

  logic accept;
  logic is_free;

  // pool size seen at address width
  logic [AW+31:0] pool_ext;
  logic [AW-1:0]  pool;

  assign pool_ext = {{AW{1'b0}}, cfg.pool_size};
  assign pool     = pool_ext[AW-1:0];

  // size rounding and bad size check on the request beat
  logic [32:0]   mask33;
  logic [CW-1:0] size_c, mask_c, sum_c, aligned_c, pool_c;
  logic          bad_in;

  assign mask33    = (33'd1 << cfg.align_shift) - 33'd1;
  assign size_c    = CW'(in_data.size);
  assign mask_c    = CW'(mask33);
  assign sum_c     = size_c + mask_c;
  assign aligned_c = sum_c & ~mask_c;
  assign pool_c    = CW'(pool);
  assign bad_in    = (in_data.size == '0) || (size_c > pool_c) || (aligned_c > pool_c);

  // liveness of the tag named by a free: inside the oldest..oldest+count-1 ring window
  logic [IW-1:0]    tag_w;
  logic [TAG_W-1:0] tag_idx;
  logic [TAG_W:0]   tag_dist;
  logic             free_live;

  assign tag_w   = IW'(in_data.tag);
  assign tag_idx = tag_w[TAG_W-1:0];

  always_comb begin
    if (tag_idx >= oldest_r) begin
      tag_dist = {1'b0, tag_idx} - {1'b0, oldest_r};
    end else begin
      tag_dist = {1'b0, tag_idx} + (TAG_W+1)'(SLOTS) - {1'b0, oldest_r};
    end
  end

  assign free_live = (tag_w < IW'(SLOTS)) && (tag_dist < (TAG_W+1)'(count_r));

  // placement decision for a pending allocation
  logic          empty;
  logic [AW-1:0] h_eff, t_eff;
  logic [AW:0]   sum_use;
  logic          no_total, ring_full, room_ok, wrap_ok, gap_ok;
  logic          place_head, place_zero, place_ok;
  logic [AW-1:0] end_head;

  assign empty     = (bytes_r == '0);
  assign h_eff     = empty ? '0 : head_r;
  assign t_eff     = empty ? '0 : tail_r;
  assign sum_use   = {1'b0, bytes_r} + {1'b0, aligned_r};
  assign no_total  = sum_use > {1'b0, pool};
  assign ring_full = !empty && (head_r == tail_r);
  assign room_ok   = (h_eff < pool) && ((pool - h_eff) >= aligned_r);
  assign wrap_ok   = t_eff >= aligned_r;
  assign gap_ok    = (t_eff - h_eff) >= aligned_r;
  assign end_head  = h_eff + aligned_r;

  always_comb begin
    if (t_eff <= h_eff) begin
      place_head = room_ok;
      place_zero = !room_ok && wrap_ok;
    end else begin
      place_head = gap_ok;
      place_zero = 1'b0;
    end
  end

  assign place_ok = !bad_r && cfg.enable && (count_r != SLOTS_CNT) && !no_total &&
                    !ring_full && (place_head || place_zero);

  // retire step on the oldest slot
  logic             retire;
  logic [TAG_W-1:0] oldest_inc, next_inc;
  logic [AW-1:0]    tail_ret, bytes_ret;

  assign retire     = (state_r == rba_pkg::S_FREE_CHK) && (count_r != '0) && rd_pend;
  assign oldest_inc = (oldest_r == SLOT_LAST) ? '0 : oldest_r + TAG_W'(1);
  assign next_inc   = (next_r == SLOT_LAST) ? '0 : next_r + TAG_W'(1);
  assign tail_ret   = (rd_end >= pool) ? '0 : rd_end;
  assign bytes_ret  = (bytes_r >= rd_len) ? bytes_r - rd_len : '0;

  assign is_free = (in_data.action == rba_pkg::ACT_FREE);
  assign accept  = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rba_pkg::S_IDLE: begin
        if (accept && !is_free) begin
          state_nxt = rba_pkg::S_DECIDE;
        end else if (accept && free_live) begin
          state_nxt = rba_pkg::S_FREE_RD;
        end
      end
      rba_pkg::S_DECIDE:   state_nxt = rba_pkg::S_IDLE;
      rba_pkg::S_FREE_RD:  state_nxt = rba_pkg::S_FREE_CHK;
      rba_pkg::S_FREE_CHK: state_nxt = retire ? rba_pkg::S_FREE_CHK : rba_pkg::S_IDLE;
    endcase
  end

  // fsm outputs: busy and slot memory access
  always_comb begin
    busy             = (state_r != rba_pkg::S_IDLE);
    mem_ctl          = '0;
    waddr            = tag_idx;
    raddr            = oldest_r;
    wr_end           = place_head ? end_head : aligned_r;
    wr_len           = aligned_r;
    unique case (state_r)
      rba_pkg::S_IDLE: begin
        // mark the freed slot pending
        mem_ctl.pend_we  = accept && is_free && free_live;
        mem_ctl.pend_bit = 1'b1;
      end
      rba_pkg::S_DECIDE: begin
        // new region takes the next slot, not pending
        waddr             = next_r;
        mem_ctl.region_we = place_ok;
        mem_ctl.pend_we   = place_ok;
        mem_ctl.pend_bit  = 1'b0;
      end
      rba_pkg::S_FREE_RD: begin
        mem_ctl.rd_en = 1'b1;
      end
      rba_pkg::S_FREE_CHK: begin
        // fetch the following slot while this one retires
        mem_ctl.rd_en = retire;
        raddr         = oldest_inc;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    bytes_nxt     = bytes_r;
    oldest_nxt    = oldest_r;
    next_nxt      = next_r;
    count_nxt     = count_r;
    retired_nxt   = retired_r;
    aligned_nxt   = aligned_r;
    bad_nxt       = bad_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      rba_pkg::S_IDLE: begin
        if (accept && is_free) begin
          if (free_live) begin
            retired_nxt = '0;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = mk_beat(rba_pkg::STAT_IGNORED, '0, '0, to_word(bytes_r), '0);
          end
        end else if (accept) begin
          aligned_nxt = aligned_c[AW-1:0];
          bad_nxt     = bad_in;
        end
      end
      rba_pkg::S_DECIDE: begin
        out_valid_nxt = 1'b1;
        priority if (bad_r) begin
          out_data_nxt = mk_beat(rba_pkg::STAT_BADSIZE, '0, '0, to_word(bytes_r), '0);
        end else if (!cfg.enable) begin
          out_data_nxt = mk_beat(rba_pkg::STAT_INACTIVE, '0, '0, to_word(bytes_r), '0);
        end else if (place_ok) begin
          head_nxt     = place_head ? end_head : aligned_r;
          tail_nxt     = t_eff;
          bytes_nxt    = bytes_r + aligned_r;
          next_nxt     = next_inc;
          count_nxt    = count_r + CNT_W'(1);
          out_data_nxt = mk_beat(rba_pkg::STAT_OK, to_word(place_head ? h_eff : '0),
                                 to_tag(next_r), to_word(bytes_r + aligned_r), '0);
        end else begin
          out_data_nxt = mk_beat(rba_pkg::STAT_RETRY, '0, '0, to_word(bytes_r), '0);
        end
      end
      rba_pkg::S_FREE_RD: begin
      end
      rba_pkg::S_FREE_CHK: begin
        if (retire) begin
          tail_nxt    = tail_ret;
          bytes_nxt   = bytes_ret;
          oldest_nxt  = oldest_inc;
          count_nxt   = count_r - CNT_W'(1);
          retired_nxt = retired_r + CNT_W'(1);
        end else begin
          // empty pool snaps both pointers home
          if (empty) begin
            head_nxt = '0;
            tail_nxt = '0;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_beat(rba_pkg::STAT_FREED, '0, '0, to_word(bytes_r),
                                  to_cnt(retired_r));
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rba_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      bytes_r     <= '0;
      oldest_r    <= '0;
      next_r      <= '0;
      count_r     <= '0;
      retired_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      bytes_r     <= bytes_nxt;
      oldest_r    <= oldest_nxt;
      next_r      <= next_nxt;
      count_r     <= count_nxt;
      retired_r   <= retired_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    aligned_r  <= aligned_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `RBA_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= SLOTS_CNT, "slot count overflow")
  `RBA_ASSERT_IMP(a_out_idle, clk, rst_n, out_valid_r, state_r == rba_pkg::S_IDLE, "result while busy")
  `RBA_ASSERT_IMP(a_empty_home, clk, rst_n, (state_r == rba_pkg::S_IDLE) && (bytes_r == '0), (head_r == '0) && (tail_r == '0), "empty pool pointers not home")
  `RBA_ASSERT_NXT(a_chk_done, clk, rst_n, (state_r == rba_pkg::S_FREE_CHK) && (count_r == '0), out_valid_r, "free did not finish on empty ring")

endmodule

[rtl/ring_buffer_allocator_unit.sv]
// Ring-buffer allocator: hands out contiguous, aligned regions of a byte pool
// in ring order and releases them from the oldest end.
// Request channel: start / busy; a beat (in_data) is taken at a clock edge
// with start high and busy low. action selects allocate or free.
// Result channel: out_valid strobes for one cycle with out_data; every request
// gives exactly one result and the receiver cannot hold it off.
// Configuration: cfg_we / cfg_index / cfg_wdata write pool_size, align_shift
// or enable, one register per write; write them only while no request is in flight.
// Allocate: busy during one placement decision (S_DECIDE), result strobe in
// the following cycle as busy drops; a new allocate is taken once busy is low.
// Free of a tag that is not live: result strobe in the cycle after the request,
// busy stays low. Free of a live tag: busy through a read of the slot memory
// (S_FREE_RD), one retire per cycle of the oldest pending regions and a final
// check (S_FREE_CHK). Result strobe in the cycle in which busy drops.
// Reset (rst_n low, synchronous): pool empty, all slots free, configuration
// back to a 1 MiB pool, 4 KiB alignment, pool enabled. The slot memory needs
// no clearing pass; the block takes requests right after reset.
module ring_buffer_allocator_unit #(
  parameter int SLOTS     = 64,
  parameter int ADDR_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  rba_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  output rba_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [rba_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [31:0]                        cfg_wdata
);

  localparam int TAG_W = $clog2(SLOTS);

  logic [31:0] pool_size_r;
  logic [4:0]  align_shift_r;
  logic        enable_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r   <= rba_pkg::POOL_SIZE_RST;
      align_shift_r <= rba_pkg::ALIGN_SHIFT_RST;
      enable_r      <= rba_pkg::ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rba_pkg::CFG_POOL_SIZE:   pool_size_r   <= cfg_wdata;
        rba_pkg::CFG_ALIGN_SHIFT: align_shift_r <= cfg_wdata[4:0];
        rba_pkg::CFG_ENABLE:      enable_r      <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  rba_pkg::cfg_t cfg;

  assign cfg.pool_size   = pool_size_r;
  assign cfg.align_shift = align_shift_r;
  assign cfg.enable      = enable_r;

  rba_pkg::mem_ctl_t    mem_ctl;
  logic [TAG_W-1:0]     waddr, raddr;
  logic [ADDR_BITS-1:0] wr_end, wr_len, rd_end, rd_len;
  logic                 rd_pend;

  // sequencer and pointer state
  rba_ctrl #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_ctl   (mem_ctl),
    .waddr     (waddr),
    .wr_end    (wr_end),
    .wr_len    (wr_len),
    .raddr     (raddr),
    .rd_end    (rd_end),
    .rd_len    (rd_len),
    .rd_pend   (rd_pend)
  );

  // per-slot region and pending store
  rba_slot_mem #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_slot_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .waddr   (waddr),
    .wr_end  (wr_end),
    .wr_len  (wr_len),
    .raddr   (raddr),
    .rd_end  (rd_end),
    .rd_len  (rd_len),
    .rd_pend (rd_pend)
  );

endmodule
